[design/vmms_pkg.sv]
`default_nettype none
package vmms_pkg;

	localparam int SAMPLE_FIELD_W = 16;
	localparam int MAG_W = 24;
	localparam int SUM_W = 32;
	localparam int STATUS_W = 2;
	localparam int FRAC_BITS = 8;
	localparam int CAPACITY_DEF = 256;
	localparam int SAMPLE_BITS_DEF = 16;

	localparam logic [STATUS_W-1:0] STATUS_OK = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_TOO_FEW = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd2;

	typedef struct packed {
		logic take_in;
		logic sq_x;
		logic sq_y;
		logic sq_z;
		logic sq_sum;
		logic sqrt_mag;
		logic store;
		logic div_mean;
		logic mean_load;
		logic rd;
		logic var_sq;
		logic var_acc;
		logic div_var;
		logic sqrt_std;
		logic std_load;
		logic load_out;
		logic clear_run;
	} vmms_cmd_t;

	typedef struct packed {
		logic sqrt_done;
		logic div_done;
		logic last;
		logic overflow;
		logic too_few;
		logic idx_last;
	} vmms_sts_t;

endpackage
`default_nettype wire

[design/vmms_if.sv]
`default_nettype none
interface vmms_sample_if;
	import vmms_pkg::*;
	logic valid;
	logic ready;
	logic signed [SAMPLE_FIELD_W-1:0] sample_x;
	logic signed [SAMPLE_FIELD_W-1:0] sample_y;
	logic signed [SAMPLE_FIELD_W-1:0] sample_z;
	logic last_sample;
	modport source (output valid, sample_x, sample_y, sample_z, last_sample, input ready);
	modport sink (input valid, sample_x, sample_y, sample_z, last_sample, output ready);
endinterface

interface vmms_result_if;
	import vmms_pkg::*;
	logic valid;
	logic ready;
	logic [MAG_W-1:0] mean_magnitude;
	logic [MAG_W-1:0] std_magnitude;
	logic [STATUS_W-1:0] status;
	modport source (output valid, mean_magnitude, std_magnitude, status, input ready);
	modport sink (input valid, mean_magnitude, std_magnitude, status, output ready);
endinterface
`default_nettype wire

[design/vmms_sqrt.sv]
`default_nettype none
module vmms_sqrt #(
	parameter int W = 66
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	input  wire logic [W-1:0] operand,
	output logic [W/2-1:0]    root,
	output logic              busy
);
	localparam int N = W / 2;
	localparam int CNTW = $clog2(N + 1);

	logic [W-1:0] v_q;
	logic [N+1:0] rem_q;
	logic [N-1:0] root_q;
	logic [CNTW-1:0] cnt_q;
	logic [N+1:0] rem_n;
	logic [N+1:0] trial;
	logic ge;

	assign rem_n = {rem_q[N-1:0], v_q[W-1:W-2]};
	assign trial = {root_q, 2'b01};
	assign ge = (rem_n >= trial);
	assign busy = (cnt_q != '0);
	assign root = root_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNTW'(N);
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v_q <= operand;
			rem_q <= '0;
			root_q <= '0;
		end else if (busy) begin
			v_q <= {v_q[W-3:0], 2'b00};
			rem_q <= ge ? (rem_n - trial) : rem_n;
			root_q <= {root_q[N-2:0], ge};
		end
	end

endmodule
`default_nettype wire

[design/vmms_div.sv]
`default_nettype none
module vmms_div #(
	parameter int DW = 56,
	parameter int VW = 9
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [DW-1:0] dividend,
	input  wire logic [VW-1:0] divisor,
	output logic [DW-1:0]      quot,
	output logic               busy
);
	localparam int CNTW = $clog2(DW + 1);

	logic [DW-1:0] dvd_q;
	logic [VW-1:0] dvs_q;
	logic [VW:0] rem_q;
	logic [CNTW-1:0] cnt_q;
	logic [VW:0] rem_n;
	logic ge;

	assign rem_n = {rem_q[VW-1:0], dvd_q[DW-1]};
	assign ge = (rem_n >= {1'b0, dvs_q});
	assign busy = (cnt_q != '0);
	assign quot = dvd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNTW'(DW);
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy) begin
			dvd_q <= {dvd_q[DW-2:0], ge};
			rem_q <= ge ? (rem_n - {1'b0, dvs_q}) : rem_n;
		end
	end

endmodule
`default_nettype wire

[design/vmms_dp.sv]
`default_nettype none
module vmms_dp #(
	parameter int CAPACITY = 256,
	parameter int SAMPLE_BITS = 16
) (
	input  wire logic                                    clk,
	input  wire logic                                    arst_n,
	input  wire vmms_pkg::vmms_cmd_t                     cmd,
	output vmms_pkg::vmms_sts_t                          sts,
	input  wire logic signed [vmms_pkg::SAMPLE_FIELD_W-1:0] sample_x,
	input  wire logic signed [vmms_pkg::SAMPLE_FIELD_W-1:0] sample_y,
	input  wire logic signed [vmms_pkg::SAMPLE_FIELD_W-1:0] sample_z,
	input  wire logic                                    last_sample,
	output logic [vmms_pkg::MAG_W-1:0]                   mean_magnitude,
	output logic [vmms_pkg::MAG_W-1:0]                   std_magnitude,
	output logic [vmms_pkg::STATUS_W-1:0]                status
);
	import vmms_pkg::*;

	localparam int SW = SAMPLE_BITS;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int IW = $clog2(CAPACITY);
	localparam int PW = 2 * MAG_W;
	localparam int QSW = PW + 2;
	localparam int AW = PW + IW;
	localparam int RW = 2 * SW + 2 + 2 * FRAC_BITS;
	localparam int QW0 = (RW > AW) ? RW : AW;
	localparam int QW = QW0 + (QW0 % 2);
	localparam int QN = QW / 2;

	logic [MAG_W-1:0] mem [CAPACITY];
	logic [MAG_W-1:0] rdata_q;
	logic [MAG_W-1:0] ax_q, ay_q, az_q;
	logic last_q;
	logic [PW-1:0] prod_q;
	logic [QSW-1:0] sq_q;
	logic [CW-1:0] count_q;
	logic [SUM_W-1:0] sum_q;
	logic ovf_q;
	logic [CW-1:0] idx_q;
	logic [AW-1:0] acc_q;
	logic [MAG_W-1:0] mean_q;
	logic [MAG_W-1:0] std_q;

	logic [SW-1:0] rx, ry, rz;
	logic [MAG_W-1:0] mul_a;
	logic [MAG_W-1:0] diff;
	logic [QN-1:0] root;
	logic [MAG_W-1:0] root_sat;
	logic sqrt_busy;
	logic [QW-1:0] sqrt_opnd;
	logic [AW-1:0] quot;
	logic div_busy;
	logic [AW-1:0] div_dvd;
	logic [CW-1:0] div_dvs;
	logic [SUM_W:0] sum_n;
	logic room;

	function automatic logic [MAG_W-1:0] abs_s(input logic [SW-1:0] v);
		logic [SW-1:0] a;
		a = v[SW-1] ? (~v + 1'b1) : v;
		return MAG_W'(a);
	endfunction

	assign rx = SW'($unsigned(sample_x));
	assign ry = SW'($unsigned(sample_y));
	assign rz = SW'($unsigned(sample_z));

	assign diff = (rdata_q >= mean_q) ? (rdata_q - mean_q) : (mean_q - rdata_q);

	always_comb begin
		mul_a = diff;
		if (cmd.sq_x) begin
			mul_a = ax_q;
		end else if (cmd.sq_y) begin
			mul_a = ay_q;
		end else if (cmd.sq_z) begin
			mul_a = az_q;
		end
	end

	assign root_sat = (|root[QN-1:MAG_W]) ? {MAG_W{1'b1}} : root[MAG_W-1:0];
	assign sqrt_opnd = cmd.sqrt_std ? QW'(quot) : QW'({sq_q, {(2 * FRAC_BITS){1'b0}}});
	assign div_dvd = cmd.div_var ? acc_q : AW'(sum_q);
	assign div_dvs = cmd.div_var ? (count_q - 1'b1) : count_q;
	assign sum_n = {1'b0, sum_q} + (SUM_W + 1)'(root_sat);
	assign room = (count_q < CW'(CAPACITY));

	vmms_sqrt #(.W(QW)) u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(cmd.sqrt_mag | cmd.sqrt_std),
		.operand(sqrt_opnd), .root(root), .busy(sqrt_busy)
	);

	vmms_div #(.DW(AW), .VW(CW)) u_div (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_mean | cmd.div_var),
		.dividend(div_dvd), .divisor(div_dvs), .quot(quot), .busy(div_busy)
	);

	always_ff @(posedge clk) begin
		if (cmd.store && room) begin
			mem[count_q[IW-1:0]] <= root_sat;
		end
		if (cmd.rd) begin
			rdata_q <= mem[idx_q[IW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take_in) begin
			ax_q <= abs_s(rx);
			ay_q <= abs_s(ry);
			az_q <= abs_s(rz);
		end
		if (cmd.sq_x || cmd.sq_y || cmd.sq_z || cmd.var_sq) begin
			prod_q <= mul_a * mul_a;
		end
		if (cmd.sq_y) begin
			sq_q <= QSW'(prod_q);
		end else if (cmd.sq_z || cmd.sq_sum) begin
			sq_q <= sq_q + QSW'(prod_q);
		end
		if (cmd.mean_load) begin
			mean_q <= quot[MAG_W-1:0];
			acc_q <= '0;
		end else if (cmd.var_acc) begin
			acc_q <= acc_q + AW'(prod_q);
		end
		if (cmd.std_load) begin
			std_q <= root_sat;
		end
		if (cmd.load_out) begin
			if (ovf_q) begin
				status <= STATUS_OVERFLOW;
				mean_magnitude <= '0;
				std_magnitude <= '0;
			end else if (count_q < CW'(2)) begin
				status <= STATUS_TOO_FEW;
				mean_magnitude <= '0;
				std_magnitude <= '0;
			end else begin
				status <= STATUS_OK;
				mean_magnitude <= mean_q;
				std_magnitude <= std_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			sum_q <= '0;
			ovf_q <= 1'b0;
			last_q <= 1'b0;
			idx_q <= '0;
		end else begin
			if (cmd.take_in) begin
				last_q <= last_sample;
			end
			if (cmd.clear_run) begin
				count_q <= '0;
				sum_q <= '0;
				ovf_q <= 1'b0;
			end else if (cmd.store) begin
				if (room) begin
					count_q <= count_q + 1'b1;
					sum_q <= sum_n[SUM_W] ? {SUM_W{1'b1}} : sum_n[SUM_W-1:0];
				end else begin
					ovf_q <= 1'b1;
				end
			end
			if (cmd.mean_load) begin
				idx_q <= '0;
			end else if (cmd.var_acc) begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	always_comb begin
		sts.sqrt_done = ~sqrt_busy;
		sts.div_done = ~div_busy;
		sts.last = last_q;
		sts.overflow = ovf_q;
		sts.too_few = (count_q < CW'(2));
		sts.idx_last = (idx_q == (count_q - 1'b1));
	end

endmodule
`default_nettype wire

[design/vmms_ctrl.sv]
`default_nettype none
module vmms_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	output logic                     out_valid,
	input  wire logic                out_ready,
	input  wire vmms_pkg::vmms_sts_t sts,
	output vmms_pkg::vmms_cmd_t      cmd
);
	import vmms_pkg::*;

	typedef enum logic [18:0] {
		ST_IDLE   = 19'd1 << 0,
		ST_SQX    = 19'd1 << 1,
		ST_SQY    = 19'd1 << 2,
		ST_SQZ    = 19'd1 << 3,
		ST_SQSUM  = 19'd1 << 4,
		ST_MSTART = 19'd1 << 5,
		ST_MWAIT  = 19'd1 << 6,
		ST_STORE  = 19'd1 << 7,
		ST_CHECK  = 19'd1 << 8,
		ST_MDIV   = 19'd1 << 9,
		ST_MDWAIT = 19'd1 << 10,
		ST_VRD    = 19'd1 << 11,
		ST_VSQ    = 19'd1 << 12,
		ST_VACC   = 19'd1 << 13,
		ST_VDIV   = 19'd1 << 14,
		ST_VDWAIT = 19'd1 << 15,
		ST_SSTART = 19'd1 << 16,
		ST_SWAIT  = 19'd1 << 17,
		ST_OUT    = 19'd1 << 18
	} state_t;

	state_t state_q, state_n;
	logic out_valid_q;
	logic out_free;

	assign out_free = ~out_valid_q | out_ready;
	assign in_ready = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_n = state_q;
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.take_in = 1'b1;
					state_n = ST_SQX;
				end
			end
			ST_SQX: begin
				cmd.sq_x = 1'b1;
				state_n = ST_SQY;
			end
			ST_SQY: begin
				cmd.sq_y = 1'b1;
				state_n = ST_SQZ;
			end
			ST_SQZ: begin
				cmd.sq_z = 1'b1;
				state_n = ST_SQSUM;
			end
			ST_SQSUM: begin
				cmd.sq_sum = 1'b1;
				state_n = ST_MSTART;
			end
			ST_MSTART: begin
				cmd.sqrt_mag = 1'b1;
				state_n = ST_MWAIT;
			end
			ST_MWAIT: begin
				if (sts.sqrt_done) begin
					state_n = ST_STORE;
				end
			end
			ST_STORE: begin
				cmd.store = 1'b1;
				state_n = sts.last ? ST_CHECK : ST_IDLE;
			end
			ST_CHECK: begin
				state_n = (sts.overflow || sts.too_few) ? ST_OUT : ST_MDIV;
			end
			ST_MDIV: begin
				cmd.div_mean = 1'b1;
				state_n = ST_MDWAIT;
			end
			ST_MDWAIT: begin
				if (sts.div_done) begin
					cmd.mean_load = 1'b1;
					state_n = ST_VRD;
				end
			end
			ST_VRD: begin
				cmd.rd = 1'b1;
				state_n = ST_VSQ;
			end
			ST_VSQ: begin
				cmd.var_sq = 1'b1;
				state_n = ST_VACC;
			end
			ST_VACC: begin
				cmd.var_acc = 1'b1;
				state_n = sts.idx_last ? ST_VDIV : ST_VRD;
			end
			ST_VDIV: begin
				cmd.div_var = 1'b1;
				state_n = ST_VDWAIT;
			end
			ST_VDWAIT: begin
				if (sts.div_done) begin
					state_n = ST_SSTART;
				end
			end
			ST_SSTART: begin
				cmd.sqrt_std = 1'b1;
				state_n = ST_SWAIT;
			end
			ST_SWAIT: begin
				if (sts.sqrt_done) begin
					cmd.std_load = 1'b1;
					state_n = ST_OUT;
				end
			end
			ST_OUT: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					cmd.clear_run = 1'b1;
					state_n = ST_IDLE;
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// no result overwritten before its transfer
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid_q || out_ready))
		else $error("result register overwritten");

	// shared units only started when idle
	a_sqrt_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.sqrt_mag || cmd.sqrt_std) |-> sts.sqrt_done)
		else $error("sqrt started while busy");

	a_div_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.div_mean || cmd.div_var) |-> sts.div_done)
		else $error("divider started while busy");

	// an unmarked sample returns straight to idle
	a_plain_sample: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_STORE && !sts.last) |=> (state_q == ST_IDLE))
		else $error("unmarked sample did not return to idle");

endmodule
`default_nettype wire

[design/vector_magnitude_mean_std_top.sv]
`default_nettype none
// Collects a run of signed three-axis samples, the last one marked, and returns one result per
// run: mean and sample standard deviation of the Q16.8 magnitudes plus a status (too few
// samples or capacity overflow give zero values). Each sample is squared axis by axis, summed
// and passed to the square root unit, whose root is N bits wide, N being half its width (28 at
// default), found one bit per cycle; the magnitude is then stored. The marked sample adds a mean
// division, a deviation sum that reads each stored magnitude in turn over the single port of the
// store, a second division and a square root, the divider being D = 48 + log2 CAPACITY bits
// wide. A finished result sits in an output register while the next run is taken in.
module vector_magnitude_mean_std_top #(
	parameter int CAPACITY = vmms_pkg::CAPACITY_DEF,
	parameter int SAMPLE_BITS = vmms_pkg::SAMPLE_BITS_DEF
) (
	input wire logic      clk,
	input wire logic      arst_n,
	vmms_sample_if.sink   samples,
	vmms_result_if.source results
);
	import vmms_pkg::*;

	vmms_cmd_t cmd;
	vmms_sts_t sts;

	vmms_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(samples.valid), .in_ready(samples.ready),
		.out_valid(results.valid), .out_ready(results.ready),
		.sts(sts), .cmd(cmd)
	);

	vmms_dp #(.CAPACITY(CAPACITY), .SAMPLE_BITS(SAMPLE_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.sample_x(samples.sample_x), .sample_y(samples.sample_y),
		.sample_z(samples.sample_z), .last_sample(samples.last_sample),
		.mean_magnitude(results.mean_magnitude),
		.std_magnitude(results.std_magnitude),
		.status(results.status)
	);

endmodule
`default_nettype wire

[sim/vmms_scoreboard.sv]
`timescale 1ns / 100ps
class vmms_scoreboard;
	logic [23:0] mags[$];
	logic [31:0] mag_sum;
	bit overflow_seen;
	logic [49:0] pending[$];
	int mismatches;

	function new();
		mag_sum = 0;
		overflow_seen = 0;
		mismatches = 0;
	endfunction

	static function longint unsigned isqrt(longint unsigned v);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv >>= 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	static function longint unsigned abs16(logic signed [15:0] s);
		longint signed t;
		t = s;
		return t < 0 ? -t : t;
	endfunction

	function void note_sample(logic signed [15:0] x, logic signed [15:0] y,
			logic signed [15:0] z, logic last);
		longint unsigned ax, ay, az, m, acc, d, sd;
		logic [23:0] mean, stdv;
		logic [1:0] status;
		ax = abs16(x);
		ay = abs16(y);
		az = abs16(z);
		if (mags.size() < 256) begin
			m = isqrt((ax * ax + ay * ay + az * az) << 16);
			if (m > 24'hFFFFFF) m = 24'hFFFFFF;
			mags.push_back(m[23:0]);
			if (64'(mag_sum) + m > 64'hFFFFFFFF) mag_sum = 32'hFFFFFFFF;
			else mag_sum = mag_sum + m[31:0];
		end else begin
			overflow_seen = 1;
		end
		if (!last) return;
		mean = 0;
		stdv = 0;
		if (overflow_seen) begin
			status = vmms_pkg::STATUS_OVERFLOW;
		end else if (mags.size() < 2) begin
			status = vmms_pkg::STATUS_TOO_FEW;
		end else begin
			status = vmms_pkg::STATUS_OK;
			mean = mag_sum / mags.size();
			acc = 0;
			foreach (mags[i]) begin
				d = mags[i] >= mean ? mags[i] - mean : mean - mags[i];
				acc += d * d;
			end
			sd = isqrt(acc / (mags.size() - 1));
			stdv = sd > 24'hFFFFFF ? 24'hFFFFFF : sd[23:0];
		end
		pending.push_back({mean, stdv, status});
		mags.delete();
		mag_sum = 0;
		overflow_seen = 0;
	endfunction

	function void check_result(logic [23:0] mean, logic [23:0] stdv, logic [1:0] status);
		logic [49:0] exp_r;
		if (pending.size() == 0) begin
			mismatches++;
			if (mismatches <= 10) $display("unexpected result %h %h %h", mean, stdv, status);
			return;
		end
		exp_r = pending.pop_front();
		if (exp_r !== {mean, stdv, status}) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch: exp mean %h std %h st %h, got mean %h std %h st %h",
					exp_r[49:26], exp_r[25:2], exp_r[1:0], mean, stdv, status);
		end
	endfunction
endclass

[sim/vector_magnitude_mean_std_top_tb.sv]
`timescale 1ns / 100ps
module vector_magnitude_mean_std_top_tb;
	import vmms_pkg::*;

	logic clk = 0;
	logic arst_n = 0;
	vmms_sample_if samples();
	vmms_result_if results();
	vmms_scoreboard stats_board = new();
	longint cycles = 0;
	bit calm = 0;

	vector_magnitude_mean_std_top u_top (
		.clk(clk), .arst_n(arst_n), .samples(samples.sink), .results(results.source)
	);

	always #5 clk = ~clk;

	initial begin
		samples.valid = 0;
		samples.sample_x = 0;
		samples.sample_y = 0;
		samples.sample_z = 0;
		samples.last_sample = 0;
		results.ready = 0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 3000000) begin
			$display("vector_magnitude_mean_std_top_tb: errors");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (results.valid && results.ready)
			stats_board.check_result(results.mean_magnitude, results.std_magnitude,
				results.status);
		results.ready <= calm || $urandom_range(99) >= 32;
	end

	function automatic logic [15:0] pick_axis();
		case ($urandom_range(5))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'($signed($urandom_range(64)) - 32);
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic send_sample(logic [15:0] x, logic [15:0] y, logic [15:0] z, logic last);
		while (!calm && $urandom_range(99) < 32) begin
			samples.valid <= 0;
			@(posedge clk);
		end
		samples.valid <= 1;
		samples.sample_x <= x;
		samples.sample_y <= y;
		samples.sample_z <= z;
		samples.last_sample <= last;
		do @(posedge clk); while (!samples.ready);
		stats_board.note_sample(x, y, z, last);
	endtask

	task automatic send_run(int n);
		for (int i = 0; i < n; i++)
			send_sample(pick_axis(), pick_axis(), pick_axis(), i == n - 1);
	endtask

	initial begin
		int sent;
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		send_sample(16'h0000, 16'h0000, 16'h0000, 1);
		send_sample(16'h8000, 16'h8000, 16'h8000, 0);
		send_sample(16'h7FFF, 16'h7FFF, 16'h7FFF, 1);
		send_sample(16'h0001, 16'hFFFF, 16'h0000, 0);
		send_sample(16'h0003, 16'h0004, 16'h0000, 0);
		send_sample(16'h8000, 16'h0000, 16'h7FFF, 1);
		send_sample(16'h0005, 16'h0005, 16'h0005, 0);
		send_sample(16'h0005, 16'h0005, 16'h0005, 1);
		for (int i = 0; i < 258; i++)
			send_sample(16'($urandom), 16'($urandom), 16'($urandom), i == 257);
		for (int i = 0; i < 256; i++)
			send_sample(16'($urandom), 16'($urandom), 16'($urandom), i == 255);
		sent = 0;
		while (sent < 1480) begin
			int n;
			calm = (sent >= 600 && sent < 900);
			case ($urandom_range(9))
				0: n = 1;
				1: n = 2;
				2: n = $urandom_range(250, 262);
				default: n = $urandom_range(3, 30);
			endcase
			send_run(n);
			sent += n;
		end
		samples.valid <= 0;
		calm = 0;
		while (stats_board.pending.size() != 0) @(posedge clk);
		repeat (1200) @(posedge clk);
		if (stats_board.mismatches == 0 && stats_board.pending.size() == 0)
			$display("vector_magnitude_mean_std_top_tb: clean");
		else
			$display("vector_magnitude_mean_std_top_tb: errors");
		$finish;
	end
endmodule
